FILE: hw/rtl/c2u_pkg.sv
// Shared types and constants of the CS0 to UTF-8 converter.
package c2u_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned MAX_RUN     = 4;
	localparam int unsigned RUN_IDX_W   = $clog2(MAX_RUN);

	localparam logic [7:0] ID_8BIT_A  = 8'd8;
	localparam logic [7:0] ID_8BIT_B  = 8'd254;
	localparam logic [7:0] ID_16BIT_A = 8'd16;
	localparam logic [7:0] ID_16BIT_B = 8'd255;

	localparam logic [15:0] LIMIT_1BYTE = 16'h0080;
	localparam logic [15:0] LIMIT_2BYTE = 16'h0800;
	localparam logic [7:0]  LEAD_2BYTE  = 8'hc0;
	localparam logic [7:0]  LEAD_3BYTE  = 8'he0;
	localparam logic [7:0]  CONT_MARK   = 8'h80;
	localparam logic [5:0]  CONT_MASK   = 6'h3f;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       is_terminator;
		logic       bad_id;
		logic       run_last;
	} result_t;

	// All results of one input byte, to go out one per cycle while popped.
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;
		logic [RUN_IDX_W-1:0]    last_idx;
		logic                    term_last;
		logic                    bad;
	} job_t;

endpackage

FILE: hw/rtl/c2u_front.sv
// Front end: tracks the string phase and turns each byte into a run of zero or more results.
module c2u_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  c2u_pkg::in_item_t item,
	output logic              job_push,
	output c2u_pkg::job_t     job
);
	import c2u_pkg::*;

	typedef enum logic [2:0] {
		PH_ID   = 3'd0,
		PH_B8   = 3'd1,
		PH_HI   = 3'd2,
		PH_LO   = 3'd3,
		PH_SKIP = 3'd4
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;

	logic [15:0]                 chr;
	logic [MAX_RUN-1:0][7:0]     enc_bytes;
	logic [RUN_IDX_W-1:0]        enc_last;
	logic                        emit;
	logic                        is_valid_id;
	logic                        is_8bit_id;
	logic [7:0]                  b;
	logic                        last;

	assign b    = item.in_byte;
	assign last = item.last_of_string;
	assign chr  = (phase_q == PH_LO) ? {held_q, b} : {8'h00, b};

	assign is_8bit_id  = (b == ID_8BIT_A) || (b == ID_8BIT_B);
	assign is_valid_id = is_8bit_id || (b == ID_16BIT_A) || (b == ID_16BIT_B);

	always_comb begin
		enc_bytes = '0;
		if (chr < LIMIT_1BYTE) begin
			enc_bytes[0] = chr[7:0];
			enc_last     = RUN_IDX_W'(0);
		end else if (chr < LIMIT_2BYTE) begin
			enc_bytes[0] = LEAD_2BYTE | {3'b000, chr[10:6]};
			enc_bytes[1] = CONT_MARK | {2'b00, chr[5:0] & CONT_MASK};
			enc_last     = RUN_IDX_W'(1);
		end else begin
			enc_bytes[0] = LEAD_3BYTE | {4'h0, chr[15:12]};
			enc_bytes[1] = CONT_MARK | {2'b00, chr[11:6]};
			enc_bytes[2] = CONT_MARK | {2'b00, chr[5:0] & CONT_MASK};
			enc_last     = RUN_IDX_W'(2);
		end
	end

	always_comb begin
		job     = '0;
		emit    = 1'b0;
		phase_d = phase_q;
		held_d  = held_q;
		unique case (phase_q) inside
			PH_B8, PH_LO: begin
				emit = 1'b1;
				if (chr == 16'h0000) begin
					// A zero character ends the string early.
					job.term_last = 1'b1;
					phase_d       = last ? PH_ID : PH_SKIP;
				end else begin
					job.bytes = enc_bytes;
					if (last) begin
						job.last_idx  = enc_last + RUN_IDX_W'(1);
						job.term_last = 1'b1;
						phase_d       = PH_ID;
					end else begin
						job.last_idx = enc_last;
						phase_d      = (phase_q == PH_LO) ? PH_HI : PH_B8;
					end
				end
			end
			PH_HI: begin
				held_d = b;
				if (last) begin
					emit          = 1'b1;
					job.term_last = 1'b1;
					phase_d       = PH_ID;
				end else begin
					phase_d = PH_LO;
				end
			end
			PH_SKIP: begin
				if (last) begin
					phase_d = PH_ID;
				end
			end
			default: begin
				if (is_valid_id) begin
					if (last) begin
						emit          = 1'b1;
						job.term_last = 1'b1;
						phase_d       = PH_ID;
					end else begin
						phase_d = is_8bit_id ? PH_B8 : PH_HI;
					end
				end else begin
					emit    = 1'b1;
					job.bad = 1'b1;
					phase_d = last ? PH_ID : PH_SKIP;
				end
			end
		endcase
	end

	assign job_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			held_q  <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

FILE: hw/rtl/c2u_fifo.sv
// Short job queue between the front end and the result serializer.
module c2u_fifo #(
	parameter int unsigned DEPTH = c2u_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  c2u_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output c2u_pkg::job_t head_job
);
	import c2u_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	job_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("job queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job popped from an empty queue");

endmodule

FILE: hw/rtl/c2u_back.sv
// Back end: sends each job's results one per cycle while popped, via an output register.
module c2u_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  c2u_pkg::job_t    head_job,
	output logic             head_pop,
	output logic             empty,
	input  logic             pop,
	output c2u_pkg::result_t result
);
	import c2u_pkg::*;

	logic [RUN_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	result_t              out_q;
	logic                 load;
	logic                 at_end;

	assign load     = head_valid && (!out_valid_q || pop);
	assign at_end   = (idx_q == head_job.last_idx);
	assign head_pop = load && at_end;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? '0 : idx_q + RUN_IDX_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.utf8_byte     <= head_job.bytes[idx_q];
			out_q.is_terminator <= head_job.term_last && at_end;
			out_q.bad_id        <= head_job.bad;
			out_q.run_last      <= at_end;
		end
	end

	a_idx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head_job.last_idx))
		else $error("result index ran past the end of its job");

	a_run_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |=> (out_valid_q && out_q.run_last))
		else $error("job retired without a run_last result");

endmodule

FILE: hw/rtl/cs0_to_utf8_converter.sv
// Top level of the CS0 to UTF-8 converter.
// Bytes of a CS0 string enter one per request; the first byte of each string is the
// compression ID (8 or 254 for 8-bit characters, 16 or 255 for big-endian 16-bit
// characters) and last_of_string flags the final byte. Each byte becomes zero to four
// results of one UTF-8 byte each: the character's encoding, then a zero terminator
// if the string ends there or the character is zero; an unknown ID gives one result
// with bad_id set and the rest of that string is skipped. run_last marks the final
// result of each input byte. Input is taken every cycle while the job queue has room;
// the output side delivers one result per cycle while results are popped, so a byte
// with several results holds the output until all have gone (an 8-bit character
// below 0x80 gives one result, one from 0x80 up gives two, and a three-byte
// character with its terminator gives four). A result passes through the job queue
// and the output register before it appears on the result ports. The queue depth
// (QUEUE_DEPTH jobs) sets how long input keeps flowing while the output is stalled.
module cs0_to_utf8_converter #(
	parameter int unsigned QUEUE_DEPTH = c2u_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  c2u_pkg::in_item_t item,
	output logic              empty,
	input  logic              pop,
	output c2u_pkg::result_t  result
);
	import c2u_pkg::*;

	logic accept;
	logic job_push;
	job_t job;
	logic head_valid;
	job_t head_job;
	logic head_pop;

	assign accept = push && !full;

	c2u_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.job_push (job_push),
		.job      (job)
	);

	c2u_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.wr_job     (job),
		.full       (full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	c2u_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
